// ===== hdl/azel_constant_velocity_kalman_core_defines.svh =====
// Assertion macros used by the checker file of the tracker core.
`ifndef AZEL_CONSTANT_VELOCITY_KALMAN_CORE_DEFINES_SVH
`define AZEL_CONSTANT_VELOCITY_KALMAN_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define AZCK_HOLDS(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define AZCK_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== hdl/azck_pkg.sv =====
// Package with the types, constants and helper functions of the tracker core.
`default_nettype none
package azck_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam logic [15:0] STEP_TIME_RST = 16'd655;
	localparam logic [31:0] PROC_NOISE_RST = 32'd66;
	localparam logic [31:0] MEAS_NOISE_RST = 32'd131072;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 2'd2;

	localparam int NSTEP = 26;
	localparam int STEP_W = $clog2(NSTEP);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEP - 1);

	typedef enum logic [4:0] {
		U_NOP, U_CAPTURE, U_CLEAR, U_PUBLISH,
		U_WMEAS_GO, U_WMEAS_END, U_AX_LOAD,
		U_PRED_A, U_PRED_B, U_PRED_C, U_PRED_D, U_PRED_E, U_PRED_F,
		U_WANG_GO, U_WANG_END, U_K0_GO, U_K0_END, U_K1_GO, U_K1_END,
		U_INN, U_UPD_A, U_UPD_B, U_UPD_C, U_UPD_D, U_UPD_E, U_UPD_F, U_UPD_G,
		U_STORE
	} uop_t;

	typedef struct packed {
		uop_t uop;
		logic axis;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

	function automatic uop_t uop_at(input logic [STEP_W-1:0] pc);
		uop_t u;
		case (pc)
			5'd0: u = U_WMEAS_GO;
			5'd1: u = U_WMEAS_END;
			5'd2: u = U_AX_LOAD;
			5'd3: u = U_PRED_A;
			5'd4: u = U_PRED_B;
			5'd5: u = U_PRED_C;
			5'd6: u = U_PRED_D;
			5'd7: u = U_PRED_E;
			5'd8: u = U_PRED_F;
			5'd9: u = U_WANG_GO;
			5'd10: u = U_WANG_END;
			5'd11: u = U_K0_GO;
			5'd12: u = U_K0_END;
			5'd13: u = U_K1_GO;
			5'd14: u = U_K1_END;
			5'd15: u = U_INN;
			5'd16: u = U_UPD_A;
			5'd17: u = U_UPD_B;
			5'd18: u = U_UPD_C;
			5'd19: u = U_UPD_D;
			5'd20: u = U_UPD_E;
			5'd21: u = U_UPD_F;
			5'd22: u = U_UPD_G;
			5'd23: u = U_WANG_GO;
			5'd24: u = U_WANG_END;
			5'd25: u = U_STORE;
			default: u = U_NOP;
		endcase
		return u;
	endfunction

	function automatic logic is_go(input uop_t u);
		logic r;
		case (u) inside
			U_K0_GO, U_K1_GO: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_wrap(input uop_t u);
		logic r;
		case (u) inside
			U_WMEAS_GO, U_WMEAS_END, U_WANG_GO, U_WANG_END: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) r = 32'sh7fffffff;
		else if (x < -64'sd2147483648) r = 32'sh80000000;
		else r = x[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/azck_if.sv =====
// Handshake interfaces for the measurement and estimate channels.
`default_nettype none
interface azck_meas_if;
	logic valid;
	logic ready;
	logic op;
	logic signed [31:0] az_meas;
	logic signed [31:0] el_meas;
	modport source(output valid, op, az_meas, el_meas, input ready);
	modport sink(input valid, op, az_meas, el_meas, output ready);
endinterface

interface azck_track_if;
	logic valid;
	logic ready;
	logic [24:0] az_est;
	logic signed [31:0] az_rate;
	logic signed [31:0] el_est;
	logic signed [31:0] el_rate;
	modport source(output valid, az_est, az_rate, el_est, el_rate, input ready);
	modport sink(input valid, az_est, az_rate, el_est, el_rate, output ready);
endinterface
`default_nettype wire

// ===== hdl/azck_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module azck_div #(
	parameter int DW = 48,
	parameter int DVW = 33
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [DW-1:0] dividend,
	input wire logic [DVW-1:0] divisor,
	output logic [DW-1:0] quot,
	output logic done
);
	localparam int CW = $clog2(DW + 1);

	logic busy_q;
	logic done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [DVW-1:0] rem_q;
	logic [DVW-1:0] dvs_q;
	logic [DVW:0] shifted;
	logic [DVW:0] diff;
	logic take;

	assign shifted = {rem_q, quo_q[DW-1]};
	assign diff = shifted - {1'b0, dvs_q};
	assign take = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], take};
			rem_q <= take ? diff[DVW-1:0] : shifted[DVW-1:0];
		end
	end

	assign quot = quo_q;
	assign done = done_q;
endmodule
`default_nettype wire

// ===== hdl/azck_dp.sv =====
// Datapath: configuration, filter state, shared multiplier and divider.
`default_nettype none
module azck_dp import azck_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cmd_t cmd,
	output sts_t sts,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic signed [31:0] az_meas,
	input wire logic signed [31:0] el_meas,
	output logic [24:0] az_est,
	output logic signed [31:0] az_rate,
	output logic signed [31:0] el_est,
	output logic signed [31:0] el_rate
);
	localparam int DW = 32 + FRAC_BITS;
	localparam int DVW = (FRAC_BITS + 9 > 33) ? FRAC_BITS + 9 : 33;
	localparam logic signed [63:0] FULL_T = 64'sd360 <<< FRAC_BITS;
	localparam logic signed [63:0] HALF_T = 64'sd180 <<< FRAC_BITS;
	localparam logic [DVW-1:0] FULL_D = DVW'(FULL_T);
	localparam logic signed [33:0] ONE34 = 34'sd1 <<< FRAC_BITS;
	localparam logic signed [31:0] ONE32 = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [67:0] HALF_P = 68'sd1 <<< (FRAC_BITS - 1);
	// Rounded-up 2^29 / 360; exact turn count for whole-degree parts below 2^20.
	localparam logic [20:0] TURN_RECIP = 21'd1491309;

	logic [15:0] dt_q;
	logic [31:0] qp_q;
	logic [31:0] r_q;
	logic signed [31:0] ang_st_q [2];
	logic signed [31:0] rate_st_q [2];
	logic signed [31:0] cov_q [8];

	logic signed [33:0] meas_az_q;
	logic signed [31:0] meas_el_q;
	logic signed [31:0] ang_q;
	logic signed [31:0] rate_q;
	logic signed [31:0] p_q [4];
	logic signed [31:0] n_q [4];
	logic signed [31:0] t_q;
	logic signed [63:0] acc_q;
	logic [DVW-1:0] s_q;
	logic signed [31:0] k0_q;
	logic signed [31:0] k1_q;
	logic signed [31:0] inn_q;
	logic neg_q;
	logic signed [67:0] prod_q;
	logic [31:0] wrap_mag_q;
	logic [11:0] wrap_quo_q;

	logic signed [33:0] ma;
	logic signed [33:0] mb;
	logic signed [67:0] rnd;
	logic signed [67:0] shr;
	logic signed [63:0] mr;
	logic signed [63:0] dt64;
	logic signed [63:0] qp64;
	logic signed [63:0] qv64;
	logic signed [63:0] r64;
	logic signed [63:0] s64;
	logic signed [63:0] sel_val;
	logic signed [63:0] mag;
	logic div_start;
	logic [DW-1:0] div_dvd;
	logic [DVW-1:0] div_dvs;
	logic [DW-1:0] div_quo;
	logic div_done;
	logic wrap_go;
	logic [19:0] wrap_hi;
	logic [40:0] wrap_prod;
	logic [39:0] wrap_sub;
	logic [39:0] wrap_rem;
	logic [DVW-1:0] rem_fix;
	logic signed [63:0] q64;
	logic signed [63:0] kval;
	logic signed [63:0] meas64;
	logic signed [63:0] inn64;
	logic [2:0] cbase;

	assign dt64 = $signed({48'd0, dt_q});
	assign qp64 = $signed({32'd0, qp_q});
	assign qv64 = $signed({29'd0, qp_q, 3'd0}) + $signed({31'd0, qp_q, 1'd0});
	assign r64 = (r_q == 32'd0) ? 64'sd1 : $signed({32'd0, r_q});
	assign s64 = 64'(n_q[0]) + r64;
	assign cbase = {cmd.axis, 2'b00};

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.uop)
			U_PRED_A: begin ma = 34'(rate_q); mb = 34'(dt64); end
			U_PRED_B: begin ma = 34'(dt64); mb = 34'(dt64); end
			U_PRED_C: begin
				ma = 34'(dt64);
				mb = 34'(sat32(64'(p_q[1]) + 64'(p_q[2])));
			end
			U_PRED_D: begin ma = 34'(t_q); mb = 34'(p_q[3]); end
			U_PRED_E: begin ma = 34'(dt64); mb = 34'(p_q[3]); end
			U_UPD_A: begin ma = 34'(k0_q); mb = 34'(inn_q); end
			U_UPD_B: begin ma = 34'(k1_q); mb = 34'(inn_q); end
			U_UPD_C: begin ma = ONE34 - 34'(k0_q); mb = 34'(n_q[0]); end
			U_UPD_D: begin ma = ONE34 - 34'(k0_q); mb = 34'(n_q[1]); end
			U_UPD_E: begin ma = 34'(k1_q); mb = 34'(n_q[0]); end
			U_UPD_F: begin ma = 34'(k1_q); mb = 34'(n_q[1]); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign rnd = prod_q + HALF_P;
	assign shr = rnd >>> FRAC_BITS;
	assign mr = shr[63:0];

	always_comb begin
		sel_val = '0;
		case (cmd.uop)
			U_WMEAS_GO: sel_val = 64'(meas_az_q);
			U_WANG_GO: sel_val = 64'(ang_q);
			U_K0_GO: sel_val = 64'(n_q[0]);
			U_K1_GO: sel_val = 64'(n_q[2]);
			default: sel_val = '0;
		endcase
	end

	assign mag = (sel_val < 0) ? -sel_val : sel_val;
	assign div_start = is_go(cmd.uop);
	assign div_dvd = DW'(mag[31:0]) << FRAC_BITS;
	assign div_dvs = s_q;

	azck_div #(.DW(DW), .DVW(DVW)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(div_dvs),
		.quot(div_quo),
		.done(div_done)
	);

	assign sts.div_done = div_done;

	// Reduction by a full turn: the turn count comes from the whole-degree part by a
	// reciprocal multiply in the first step, the remainder in the second.
	assign wrap_go = (cmd.uop == U_WMEAS_GO) || (cmd.uop == U_WANG_GO);
	assign wrap_hi = 20'(mag[31:0] >> FRAC_BITS);
	assign wrap_prod = 41'(wrap_hi) * 41'(TURN_RECIP);
	assign wrap_sub = (40'(wrap_quo_q) * 40'd360) << FRAC_BITS;
	assign wrap_rem = 40'(wrap_mag_q) - wrap_sub;
	assign rem_fix = (neg_q && wrap_rem != '0) ? FULL_D - wrap_rem[DVW-1:0]
		: wrap_rem[DVW-1:0];
	assign q64 = $signed(64'(div_quo));
	assign kval = neg_q ? -q64 : q64;

	always_comb begin
		meas64 = cmd.axis ? 64'(meas_el_q) : 64'(meas_az_q);
		inn64 = meas64 - 64'(ang_q);
		if (!cmd.axis) begin
			if (inn64 > HALF_T) inn64 = inn64 - FULL_T;
			else if (inn64 < -HALF_T) inn64 = inn64 + FULL_T;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= STEP_TIME_RST;
			qp_q <= PROC_NOISE_RST;
			r_q <= MEAS_NOISE_RST;
			for (int i = 0; i < 2; i++) begin
				ang_st_q[i] <= '0;
				rate_st_q[i] <= '0;
			end
			for (int i = 0; i < 8; i++) begin
				cov_q[i] <= (i == 0 || i == 3 || i == 4 || i == 7) ? ONE32 : '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_STEP_TIME: dt_q <= cfg_data[15:0];
					CFG_PROC_NOISE: qp_q <= cfg_data;
					CFG_MEAS_NOISE: r_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.uop == U_CLEAR) begin
				for (int i = 0; i < 2; i++) begin
					ang_st_q[i] <= '0;
					rate_st_q[i] <= '0;
				end
				for (int i = 0; i < 8; i++) begin
					cov_q[i] <= (i == 0 || i == 3 || i == 4 || i == 7) ? ONE32 : '0;
				end
			end else if (cmd.uop == U_STORE) begin
				ang_st_q[cmd.axis] <= ang_q;
				rate_st_q[cmd.axis] <= rate_q;
				for (int i = 0; i < 4; i++) begin
					cov_q[cbase + 3'(i)] <= p_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		if (div_start || wrap_go) neg_q <= sel_val < 0;
		if (wrap_go) begin
			wrap_mag_q <= mag[31:0];
			wrap_quo_q <= wrap_prod[40:29];
		end
		case (cmd.uop)
			U_CAPTURE: begin
				meas_az_q <= 34'(az_meas);
				meas_el_q <= el_meas;
			end
			U_PUBLISH: begin
				az_est <= ang_st_q[0][24:0];
				az_rate <= rate_st_q[0];
				el_est <= ang_st_q[1];
				el_rate <= rate_st_q[1];
			end
			U_WMEAS_END: meas_az_q <= 34'({1'b0, rem_fix});
			U_AX_LOAD: begin
				ang_q <= ang_st_q[cmd.axis];
				rate_q <= rate_st_q[cmd.axis];
				for (int i = 0; i < 4; i++) begin
					p_q[i] <= cov_q[cbase + 3'(i)];
				end
			end
			U_PRED_B: ang_q <= sat32(64'(ang_q) + mr);
			U_PRED_C: t_q <= mr[31:0];
			U_PRED_D: acc_q <= 64'(p_q[0]) + mr + qp64;
			U_PRED_E: n_q[0] <= sat32(acc_q + mr);
			U_PRED_F: begin
				n_q[1] <= sat32(64'(p_q[1]) + mr);
				n_q[2] <= sat32(64'(p_q[2]) + mr);
				n_q[3] <= sat32(64'(p_q[3]) + qv64);
				s_q <= (s64 < 64'sd1) ? DVW'(1) : s64[DVW-1:0];
			end
			U_WANG_END: ang_q <= sat32($signed(64'(rem_fix)));
			U_K0_END: k0_q <= sat32(kval);
			U_K1_END: k1_q <= sat32(kval);
			U_INN: inn_q <= sat32(inn64);
			U_UPD_B: ang_q <= sat32(64'(ang_q) + mr);
			U_UPD_C: rate_q <= sat32(64'(rate_q) + mr);
			U_UPD_D: p_q[0] <= sat32(mr);
			U_UPD_E: p_q[1] <= sat32(mr);
			U_UPD_F: p_q[2] <= sat32(64'(n_q[2]) - mr);
			U_UPD_G: p_q[3] <= sat32(64'(n_q[3]) - mr);
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/azck_ctrl.sv =====
// Controller: handshakes and the step sequence of one filter update.
`default_nettype none
module azck_ctrl import azck_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_op,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	output cmd_t cmd,
	input wire sts_t sts
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RUN = 4'b0010,
		S_DIVW = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;
	logic [STEP_W-1:0] pc_q;
	logic axis_q;
	logic out_valid_q;
	uop_t step;
	logic skip;
	logic can_pub;

	assign step = uop_at(pc_q);
	assign skip = axis_q && is_wrap(step);
	assign can_pub = !out_valid_q || out_ready;
	assign in_ready = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.axis = axis_q;
		cmd.uop = U_NOP;
		unique case (state_q)
			S_IDLE: if (in_valid) cmd.uop = in_op ? U_CLEAR : U_CAPTURE;
			S_RUN: cmd.uop = skip ? U_NOP : step;
			S_DIVW: cmd.uop = U_NOP;
			S_DONE: if (can_pub) cmd.uop = U_PUBLISH;
			default: cmd.uop = U_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			axis_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && can_pub) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pc_q <= '0;
						axis_q <= 1'b0;
						state_q <= in_op ? S_DONE : S_RUN;
					end
				end
				S_RUN: begin
					if (pc_q == LAST_STEP) begin
						pc_q <= '0;
						if (axis_q) state_q <= S_DONE;
						else axis_q <= 1'b1;
					end else if (!skip && is_go(step)) begin
						state_q <= S_DIVW;
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
				S_DIVW: begin
					if (sts.div_done) begin
						pc_q <= pc_q + 1'b1;
						state_q <= S_RUN;
					end
				end
				S_DONE: begin
					if (can_pub) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hdl/azel_constant_velocity_kalman_core.sv =====
// Two-axis constant-velocity Kalman tracker core, top level.
// Each measurement word runs both axes through a 26-step sequence on one shared
// multiplier and one bit-serial divider; the two gain divisions per axis set the pace,
// each holding the sequence until the divider reports done. Azimuth reduction by a full
// turn uses a reciprocal multiply over two steps. A finished update or clear word waits
// while the previous estimate word is not taken. The default format is Q16.16.
// The estimate register lets a new word be accepted while the last result waits.
`default_nettype none
module azel_constant_velocity_kalman_core import azck_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	azck_meas_if.sink meas_ch,
	azck_track_if.source track_ch,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;

	azck_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(meas_ch.valid),
		.in_op(meas_ch.op),
		.in_ready(meas_ch.ready),
		.out_valid(track_ch.valid),
		.out_ready(track_ch.ready),
		.cmd(cmd),
		.sts(sts)
	);

	azck_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.az_meas(meas_ch.az_meas),
		.el_meas(meas_ch.el_meas),
		.az_est(track_ch.az_est),
		.az_rate(track_ch.az_rate),
		.el_est(track_ch.el_est),
		.el_rate(track_ch.el_rate)
	);
endmodule
`default_nettype wire

// ===== hdl/azck_checker.sv =====
// Port-level checker for the tracker core and its bind.
`default_nettype none
`include "azel_constant_velocity_kalman_core_defines.svh"
module azck_checker #(
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [24:0] az_est,
	input wire logic signed [31:0] az_rate
);
	localparam logic [63:0] FULL_T = 64'd360 << FRAC_BITS;

	`AZCK_NEXT(a_valid_hold, out_valid && !out_ready, out_valid, "estimate word dropped")
	`AZCK_NEXT(a_word_stable, out_valid && !out_ready, $stable(az_est) && $stable(az_rate), "estimate word changed while stalled")
	`AZCK_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second word accepted during an update")
	`AZCK_HOLDS(a_az_range, out_valid, (FRAC_BITS > 16) || ({39'd0, az_est} < FULL_T), "azimuth estimate out of range")
endmodule

bind azel_constant_velocity_kalman_core azck_checker #(.FRAC_BITS(FRAC_BITS)) u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(meas_ch.valid),
	.in_ready(meas_ch.ready),
	.out_valid(track_ch.valid),
	.out_ready(track_ch.ready),
	.az_est(track_ch.az_est),
	.az_rate(track_ch.az_rate)
);
`default_nettype wire
